// ----- hdl/sctk_pkg.sv -----
// ----------------------------------------------------------------------------
// sctk_pkg: shared types and constants of the scancode to key decoder
// Transfer payloads, the modifier flag group, set-1 scancodes, special key
// numbers and the plain and shifted ASCII lookup tables.
// ----------------------------------------------------------------------------
package sctk_pkg;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] scan_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [5:0] special_key;
  } out_item_t;

  typedef struct packed {
    logic shift_held;
    logic ctrl_held;
    logic caps_on;
    logic extended_pending;
  } key_flags_t;

  // Status byte bits.
  localparam int unsigned ST_DATA_READY = 0;
  localparam int unsigned ST_MOUSE_DATA = 5;

  // Set-1 scancodes with special meaning.
  localparam logic [7:0] SC_ESC         = 8'h01;
  localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [7:0] SC_TAB         = 8'h0F;
  localparam logic [7:0] SC_E           = 8'h12;
  localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
  localparam logic [7:0] SC_A           = 8'h1E;
  localparam logic [7:0] SC_F           = 8'h21;
  localparam logic [7:0] SC_H           = 8'h23;
  localparam logic [7:0] SC_K           = 8'h25;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_Z           = 8'h2C;
  localparam logic [7:0] SC_X           = 8'h2D;
  localparam logic [7:0] SC_C           = 8'h2E;
  localparam logic [7:0] SC_V           = 8'h2F;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;
  localparam logic [7:0] SC_HOME        = 8'h47;
  localparam logic [7:0] SC_UP          = 8'h48;
  localparam logic [7:0] SC_PGUP        = 8'h49;
  localparam logic [7:0] SC_LEFT        = 8'h4B;
  localparam logic [7:0] SC_RIGHT       = 8'h4D;
  localparam logic [7:0] SC_END         = 8'h4F;
  localparam logic [7:0] SC_DOWN        = 8'h50;
  localparam logic [7:0] SC_PGDN        = 8'h51;
  localparam logic [7:0] SC_DEL         = 8'h53;
  localparam logic [7:0] SC_CTRL_BREAK  = 8'h9D;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_EXT_PREFIX  = 8'hE0;

  // Number of scancodes covered by the ASCII tables.
  localparam logic [7:0] ROM_SIZE = 8'd58;

  localparam logic [6:0] CHAR_NONE  = 7'd0;
  localparam logic [6:0] CHAR_ESC   = 7'd27;
  localparam logic [6:0] CHAR_LOW_A = 7'h61;
  localparam logic [6:0] CHAR_LOW_Z = 7'h7A;
  localparam logic [6:0] CASE_DIFF  = 7'd32;

  // Special key numbers.
  localparam logic [5:0] SK_NONE             = 6'd0;
  localparam logic [5:0] SK_CTRL_F           = 6'd1;
  localparam logic [5:0] SK_CTRL_C           = 6'd2;
  localparam logic [5:0] SK_CTRL_V           = 6'd3;
  localparam logic [5:0] SK_CTRL_SHIFT_A     = 6'd4;
  localparam logic [5:0] SK_CTRL_A           = 6'd5;
  localparam logic [5:0] SK_CTRL_E           = 6'd6;
  localparam logic [5:0] SK_CTRL_SHIFT_Z     = 6'd7;
  localparam logic [5:0] SK_CTRL_Z           = 6'd8;
  localparam logic [5:0] SK_CTRL_K           = 6'd9;
  localparam logic [5:0] SK_CTRL_SHIFT_X     = 6'd10;
  localparam logic [5:0] SK_CTRL_X           = 6'd11;
  localparam logic [5:0] SK_CTRL_BACKSPACE   = 6'd12;
  localparam logic [5:0] SK_CTRL_H           = 6'd13;
  localparam logic [5:0] SK_CTRL_ESC         = 6'd14;
  localparam logic [5:0] SK_SHIFT_ESC        = 6'd15;
  localparam logic [5:0] SK_CTRL_DEL         = 6'd16;
  localparam logic [5:0] SK_DEL              = 6'd17;
  localparam logic [5:0] SK_HOME             = 6'd18;
  localparam logic [5:0] SK_END              = 6'd19;
  localparam logic [5:0] SK_SHIFT_UP         = 6'd20;
  localparam logic [5:0] SK_UP               = 6'd21;
  localparam logic [5:0] SK_SHIFT_DOWN       = 6'd22;
  localparam logic [5:0] SK_DOWN             = 6'd23;
  localparam logic [5:0] SK_CTRL_SHIFT_LEFT  = 6'd24;
  localparam logic [5:0] SK_CTRL_LEFT        = 6'd25;
  localparam logic [5:0] SK_SHIFT_LEFT       = 6'd26;
  localparam logic [5:0] SK_LEFT             = 6'd27;
  localparam logic [5:0] SK_CTRL_SHIFT_RIGHT = 6'd28;
  localparam logic [5:0] SK_CTRL_RIGHT       = 6'd29;
  localparam logic [5:0] SK_SHIFT_RIGHT      = 6'd30;
  localparam logic [5:0] SK_RIGHT            = 6'd31;
  localparam logic [5:0] SK_PGUP             = 6'd32;
  localparam logic [5:0] SK_PGDN             = 6'd33;
  localparam logic [5:0] SK_SHIFT_TAB        = 6'd34;
  localparam logic [5:0] SK_TAB              = 6'd35;
  localparam logic [5:0] SK_LAST             = SK_TAB;

  // Unshifted ASCII table, indexed by make code.
  function automatic logic [6:0] rom_plain(input logic [5:0] idx);
    logic [6:0] v;
    unique case (idx)
      6'd1:  v = 7'h1B;  6'd2:  v = 7'h31;  6'd3:  v = 7'h32;  6'd4:  v = 7'h33;
      6'd5:  v = 7'h34;  6'd6:  v = 7'h35;  6'd7:  v = 7'h36;  6'd8:  v = 7'h37;
      6'd9:  v = 7'h38;  6'd10: v = 7'h39;  6'd11: v = 7'h30;  6'd12: v = 7'h2D;
      6'd13: v = 7'h3D;  6'd14: v = 7'h08;  6'd15: v = 7'h09;  6'd16: v = 7'h71;
      6'd17: v = 7'h77;  6'd18: v = 7'h65;  6'd19: v = 7'h72;  6'd20: v = 7'h74;
      6'd21: v = 7'h79;  6'd22: v = 7'h75;  6'd23: v = 7'h69;  6'd24: v = 7'h6F;
      6'd25: v = 7'h70;  6'd26: v = 7'h5B;  6'd27: v = 7'h5D;  6'd28: v = 7'h0A;
      6'd30: v = 7'h61;  6'd31: v = 7'h73;  6'd32: v = 7'h64;  6'd33: v = 7'h66;
      6'd34: v = 7'h67;  6'd35: v = 7'h68;  6'd36: v = 7'h6A;  6'd37: v = 7'h6B;
      6'd38: v = 7'h6C;  6'd39: v = 7'h3B;  6'd40: v = 7'h27;  6'd41: v = 7'h60;
      6'd43: v = 7'h5C;  6'd44: v = 7'h7A;  6'd45: v = 7'h78;  6'd46: v = 7'h63;
      6'd47: v = 7'h76;  6'd48: v = 7'h62;  6'd49: v = 7'h6E;  6'd50: v = 7'h6D;
      6'd51: v = 7'h2C;  6'd52: v = 7'h2E;  6'd53: v = 7'h2F;  6'd55: v = 7'h2A;
      6'd57: v = 7'h20;
      default: v = CHAR_NONE;
    endcase
    return v;
  endfunction

  // Shifted ASCII table, indexed by make code.
  function automatic logic [6:0] rom_shift(input logic [5:0] idx);
    logic [6:0] v;
    unique case (idx)
      6'd1:  v = 7'h1B;  6'd2:  v = 7'h21;  6'd3:  v = 7'h40;  6'd4:  v = 7'h23;
      6'd5:  v = 7'h24;  6'd6:  v = 7'h25;  6'd7:  v = 7'h5E;  6'd8:  v = 7'h26;
      6'd9:  v = 7'h2A;  6'd10: v = 7'h28;  6'd11: v = 7'h29;  6'd12: v = 7'h5F;
      6'd13: v = 7'h2B;  6'd14: v = 7'h08;  6'd15: v = 7'h09;  6'd16: v = 7'h51;
      6'd17: v = 7'h57;  6'd18: v = 7'h45;  6'd19: v = 7'h52;  6'd20: v = 7'h54;
      6'd21: v = 7'h59;  6'd22: v = 7'h55;  6'd23: v = 7'h49;  6'd24: v = 7'h4F;
      6'd25: v = 7'h50;  6'd26: v = 7'h7B;  6'd27: v = 7'h7D;  6'd28: v = 7'h0A;
      6'd30: v = 7'h41;  6'd31: v = 7'h53;  6'd32: v = 7'h44;  6'd33: v = 7'h46;
      6'd34: v = 7'h47;  6'd35: v = 7'h48;  6'd36: v = 7'h4A;  6'd37: v = 7'h4B;
      6'd38: v = 7'h4C;  6'd39: v = 7'h3A;  6'd40: v = 7'h22;  6'd41: v = 7'h7E;
      6'd43: v = 7'h7C;  6'd44: v = 7'h5A;  6'd45: v = 7'h58;  6'd46: v = 7'h43;
      6'd47: v = 7'h56;  6'd48: v = 7'h42;  6'd49: v = 7'h4E;  6'd50: v = 7'h4D;
      6'd51: v = 7'h3C;  6'd52: v = 7'h3E;  6'd53: v = 7'h3F;  6'd55: v = 7'h2A;
      6'd57: v = 7'h20;
      default: v = CHAR_NONE;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/sctk_decode.sv -----
// ----------------------------------------------------------------------------
// sctk_decode: single-pass decode of one controller poll
// Combinational: from the registered poll and the current modifier flags it
// forms the result item and the flags that follow this poll.
// ----------------------------------------------------------------------------
module sctk_decode (
  input  sctk_pkg::in_item_t   item_i,
  input  sctk_pkg::key_flags_t flags_i,
  output sctk_pkg::out_item_t  result_o,
  output sctk_pkg::key_flags_t flags_nxt_o
);

  logic [7:0] sc;
  logic       s;
  logic       c;
  logic       data_ok;
  logic [5:0] shortcut;
  logic [5:0] nav;
  logic [6:0] rom_v;

  assign sc      = item_i.scan_byte;
  assign s       = flags_i.shift_held;
  assign c       = flags_i.ctrl_held;
  assign data_ok = item_i.status_byte[sctk_pkg::ST_DATA_READY] &&
                   !item_i.status_byte[sctk_pkg::ST_MOUSE_DATA];

  // Ctrl shortcuts; only taken when ctrl is held.
  always_comb begin
    unique case (sc)
      sctk_pkg::SC_F:         shortcut = sctk_pkg::SK_CTRL_F;
      sctk_pkg::SC_C:         shortcut = sctk_pkg::SK_CTRL_C;
      sctk_pkg::SC_V:         shortcut = sctk_pkg::SK_CTRL_V;
      sctk_pkg::SC_A:         shortcut = s ? sctk_pkg::SK_CTRL_SHIFT_A : sctk_pkg::SK_CTRL_A;
      sctk_pkg::SC_E:         shortcut = sctk_pkg::SK_CTRL_E;
      sctk_pkg::SC_Z:         shortcut = s ? sctk_pkg::SK_CTRL_SHIFT_Z : sctk_pkg::SK_CTRL_Z;
      sctk_pkg::SC_K:         shortcut = sctk_pkg::SK_CTRL_K;
      sctk_pkg::SC_X:         shortcut = s ? sctk_pkg::SK_CTRL_SHIFT_X : sctk_pkg::SK_CTRL_X;
      sctk_pkg::SC_BACKSPACE: shortcut = sctk_pkg::SK_CTRL_BACKSPACE;
      sctk_pkg::SC_H:         shortcut = sctk_pkg::SK_CTRL_H;
      default:                shortcut = sctk_pkg::SK_NONE;
    endcase
  end

  // Navigation and editing keys.
  always_comb begin
    unique case (sc)
      sctk_pkg::SC_DEL:   nav = c ? sctk_pkg::SK_CTRL_DEL : sctk_pkg::SK_DEL;
      sctk_pkg::SC_HOME:  nav = sctk_pkg::SK_HOME;
      sctk_pkg::SC_END:   nav = sctk_pkg::SK_END;
      sctk_pkg::SC_UP:    nav = s ? sctk_pkg::SK_SHIFT_UP : sctk_pkg::SK_UP;
      sctk_pkg::SC_DOWN:  nav = s ? sctk_pkg::SK_SHIFT_DOWN : sctk_pkg::SK_DOWN;
      sctk_pkg::SC_LEFT:  nav = (c && s) ? sctk_pkg::SK_CTRL_SHIFT_LEFT :
                                c ? sctk_pkg::SK_CTRL_LEFT :
                                s ? sctk_pkg::SK_SHIFT_LEFT : sctk_pkg::SK_LEFT;
      sctk_pkg::SC_RIGHT: nav = (c && s) ? sctk_pkg::SK_CTRL_SHIFT_RIGHT :
                                c ? sctk_pkg::SK_CTRL_RIGHT :
                                s ? sctk_pkg::SK_SHIFT_RIGHT : sctk_pkg::SK_RIGHT;
      sctk_pkg::SC_PGUP:  nav = sctk_pkg::SK_PGUP;
      sctk_pkg::SC_PGDN:  nav = sctk_pkg::SK_PGDN;
      sctk_pkg::SC_TAB:   nav = s ? sctk_pkg::SK_SHIFT_TAB : sctk_pkg::SK_TAB;
      default:            nav = sctk_pkg::SK_NONE;
    endcase
  end

  // Character lookup; caps lock raises lowercase letters when unshifted.
  always_comb begin
    if (s) begin
      rom_v = sctk_pkg::rom_shift(sc[5:0]);
    end else begin
      rom_v = sctk_pkg::rom_plain(sc[5:0]);
      if (flags_i.caps_on && rom_v >= sctk_pkg::CHAR_LOW_A &&
          rom_v <= sctk_pkg::CHAR_LOW_Z) begin
        rom_v = rom_v - sctk_pkg::CASE_DIFF;
      end
    end
  end

  always_comb begin
    flags_nxt_o = flags_i;
    result_o    = '0;
    if (data_ok) begin
      if (sc == sctk_pkg::SC_EXT_PREFIX) begin
        flags_nxt_o.extended_pending = 1'b1;
      end else begin
        flags_nxt_o.extended_pending = 1'b0;
        priority if (sc == sctk_pkg::SC_CTRL_MAKE) begin
          flags_nxt_o.ctrl_held = 1'b1;
        end else if (sc == sctk_pkg::SC_CTRL_BREAK) begin
          flags_nxt_o.ctrl_held = 1'b0;
        end else if (sc == sctk_pkg::SC_LSHIFT_BRK || sc == sctk_pkg::SC_RSHIFT_BRK) begin
          if (!flags_i.extended_pending) begin
            flags_nxt_o.shift_held = 1'b0;
          end
        end else if (sc == sctk_pkg::SC_LSHIFT_MAKE || sc == sctk_pkg::SC_RSHIFT_MAKE) begin
          if (!flags_i.extended_pending) begin
            flags_nxt_o.shift_held = 1'b1;
          end
        end else if (sc == sctk_pkg::SC_CAPS_MAKE) begin
          flags_nxt_o.caps_on = !flags_i.caps_on;
        end else if (sc[7]) begin
          result_o = '0;
        end else if (c && shortcut != sctk_pkg::SK_NONE) begin
          result_o.special_key = shortcut;
        end else if (sc == sctk_pkg::SC_ESC) begin
          if (c) begin
            result_o.special_key = sctk_pkg::SK_CTRL_ESC;
          end else if (s) begin
            result_o.special_key = sctk_pkg::SK_SHIFT_ESC;
          end else begin
            result_o.char_code = sctk_pkg::CHAR_ESC;
          end
        end else if (nav != sctk_pkg::SK_NONE) begin
          result_o.special_key = nav;
        end else if (sc < sctk_pkg::ROM_SIZE) begin
          result_o.char_code = rom_v;
        end else begin
          result_o = '0;
        end
      end
    end
  end

endmodule

// ----- hdl/scancode_to_key_decoder.sv -----
// ----------------------------------------------------------------------------
// scancode_to_key_decoder: set-1 keyboard scancode to key decoder
// Decodes one keyboard controller poll per transfer into an ASCII character
// or a special key number, tracking shift, ctrl, caps lock and the E0 prefix.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                              | Payload
//  --------+------------------------------------+-----------------------------
//  input   | in_valid, in_ready, in_data        | status_byte, scan_byte
//  result  | out_valid, out_ready, out_data     | char_code, special_key
//
// One poll per cycle while the result is not stalled, one result transfer per
// poll: the input register feeds a single combinational decode into the result
// register, so each poll passes the input register and then the result register.
// Reset (rst_n low, synchronous) empties both registers and clears all flags.
// A stalled result holds both registers; in_ready drops only when both are
// full and out_ready is low.
//
module scancode_to_key_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sctk_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sctk_pkg::out_item_t out_data
);

  // Input register stage.
  logic                 in_valid_r;
  sctk_pkg::in_item_t   in_item_r;

  // Result register stage.
  logic                 out_valid_r;
  sctk_pkg::out_item_t  out_item_r;

  // Modifier flags; they advance exactly when a poll moves into the result
  // register, so each poll sees the flags left by the poll before it.
  sctk_pkg::key_flags_t flags_r;
  sctk_pkg::key_flags_t flags_nxt;
  sctk_pkg::out_item_t  result_nxt;

  logic advance;

  // The decoded poll moves on when the result register is empty or being
  // drained in this same cycle.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  // The input register can take a new poll when it is empty or its poll
  // moves on in this cycle.
  assign in_ready = !in_valid_r || advance;

  sctk_decode u_decode (
    .item_i      (in_item_r),
    .flags_i     (flags_r),
    .result_o    (result_nxt),
    .flags_nxt_o (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (advance) begin
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // A result never carries both a character and a special key.
  a_exclusive_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.char_code == sctk_pkg::CHAR_NONE ||
                     out_item_r.special_key == sctk_pkg::SK_NONE))
    else $error("result carries both a character and a special key");

  // Special key numbers stay within the defined range.
  a_special_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.special_key <= sctk_pkg::SK_LAST))
    else $error("special key number out of range");

  // Back-pressure reaches the input only when both stages are full and stalled.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while a stage is free");

  // Flags change only when a poll is decoded.
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(flags_r))
    else $error("modifier flags changed without a decoded poll");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule
